@@ hw/rtl/go_back_n_send_window_macros.svh @@
// go_back_n_send_window_macros.svh: assertion macros for the send window rtl
// used by go_back_n_send_window.sv; no other dependencies
`ifndef GO_BACK_N_SEND_WINDOW_MACROS_SVH
`define GO_BACK_N_SEND_WINDOW_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, disabled while reset is asserted
`define GBNSW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("send window assertion failed");

// next-cycle implication, disabled while reset is asserted
`define GBNSW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("send window assertion failed");

`else

`define GBNSW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define GBNSW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/gbnsw_pkg.sv @@
// gbnsw_pkg: shared types, codes and widths of the go-back-n send window
// no dependencies
`default_nettype none

package gbnsw_pkg;

	// field widths
	localparam int unsigned OPCODE_W  = 2;
	localparam int unsigned CHAN_W    = 10;
	localparam int unsigned SEQ_W     = 32;
	localparam int unsigned PTYPE_W   = 8;
	localparam int unsigned LEN_W     = 16;
	localparam int unsigned ADDR_W    = 32;
	localparam int unsigned STATUS_W  = 3;
	localparam int unsigned OUTST_W   = 5;

	// stream widths, padded to whole bytes
	localparam int unsigned IN_FIELDS_W  = CHAN_W + SEQ_W + PTYPE_W + LEN_W + ADDR_W;
	localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int unsigned IN_PAD_W     = IN_TDATA_W - IN_FIELDS_W;
	localparam int unsigned OUT_FIELDS_W = STATUS_W + CHAN_W + SEQ_W + PTYPE_W + LEN_W
		+ ADDR_W + OUTST_W;
	localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int unsigned OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

	// defaults
	localparam int unsigned DEFAULT_WINDOW_DEPTH = 16;
	localparam int unsigned CMD_FIFO_DEPTH       = 2;
	localparam logic [PTYPE_W-1:0] ACK_TYPE_RESET = 8'd1;

	// input opcodes
	localparam logic [OPCODE_W-1:0] OP_ENQ    = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_ACK    = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_TMO    = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

	// classified commands between front and back
	localparam logic [1:0] CMD_ENQ     = 2'd0;
	localparam logic [1:0] CMD_ACK     = 2'd1;
	localparam logic [1:0] CMD_ACK_IGN = 2'd2;
	localparam logic [1:0] CMD_TMO     = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_ACCEPTED = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_DROPPED  = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_RETIRED  = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_IGNORED  = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd4;

	// result kinds
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_DESC   = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0]  buf_addr;
		logic [LEN_W-1:0]   len;
		logic [PTYPE_W-1:0] ptype;
		logic [SEQ_W-1:0]   seq;
		logic [CHAN_W-1:0]  chan;
	} desc_t;

	typedef struct packed {
		logic [1:0] kind;
		desc_t      desc;
	} cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/gbnsw_front.sv @@
// gbnsw_front: input transfer, ack code register and command classification
// depends on gbnsw_pkg
`default_nettype none

module gbnsw_front
	import gbnsw_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_TDATA_W-1:0] s_tdata,
	input  wire logic [OPCODE_W-1:0]   s_tuser,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [PTYPE_W-1:0]    cfg_data,
	output logic                       push_valid,
	input  wire logic                  push_ready,
	output cmd_t                       push_cmd
);

	logic [PTYPE_W-1:0] ack_code_q;
	logic               v_s1;
	cmd_t               cmd_s1;
	cmd_t               cmd_in;
	logic               accept;

	assign cfg_ready = 1'b1;
	assign s_tready  = !v_s1 || push_ready;
	assign accept    = s_tvalid && s_tready;

	always_comb begin
		cmd_in.desc = desc_t'(s_tdata[IN_FIELDS_W-1:0]);
		case (s_tuser)
			OP_ENQ: cmd_in.kind = CMD_ENQ;
			OP_ACK: cmd_in.kind = (cmd_in.desc.ptype == ack_code_q) ? CMD_ACK : CMD_ACK_IGN;
			OP_TMO: cmd_in.kind = CMD_TMO;
			default: cmd_in.kind = CMD_ENQ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_code_q <= ACK_TYPE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			ack_code_q <= cfg_data;
		end
	end

	// unused opcode is swallowed here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= (s_tuser != OP_UNUSED);
		end else if (push_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_in;
		end
	end

	assign push_valid = v_s1;
	assign push_cmd   = cmd_s1;

endmodule

`default_nettype wire

@@ hw/rtl/gbnsw_cmd_fifo.sv @@
// gbnsw_cmd_fifo: short command queue between front and back
// depends on gbnsw_pkg
`default_nettype none

module gbnsw_cmd_fifo
	import gbnsw_pkg::*;
#(
	parameter int unsigned DEPTH = CMD_FIFO_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  wire cmd_t push_cmd,
	output logic      pop_valid,
	input  wire logic pop,
	output cmd_t      pop_cmd
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (cnt_q != FULL_CNT);
	assign pop_valid  = (cnt_q != '0);
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/gbnsw_back.sv @@
// gbnsw_back: descriptor ring, head/tail/occupancy and result output register
// depends on gbnsw_pkg
`default_nettype none

module gbnsw_back
	import gbnsw_pkg::*;
#(
	parameter int unsigned WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH,
	localparam int unsigned OCC_W = $clog2(WINDOW_DEPTH + 1)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cmd_valid,
	output logic                        cmd_pop,
	input  wire cmd_t                   cmd,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	output logic                        m_tuser,
	output logic                        m_tlast,
	output logic [OCC_W-1:0]            occupancy
);

	localparam int unsigned IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);
	localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(WINDOW_DEPTH);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_ACK    = 2'd1;
	localparam logic [1:0] ST_REPLAY = 2'd2;

	desc_t              mem [WINDOW_DEPTH];
	desc_t              rd_data_q;
	logic [IDX_W-1:0]   rd_addr;
	logic               wr_en;

	logic [1:0]         state_q, state_d;
	logic [IDX_W-1:0]   head_q, head_d, head_nxt;
	logic [IDX_W-1:0]   tail_q, tail_d, tail_nxt;
	logic [IDX_W-1:0]   ptr_q, ptr_d, ptr_nxt;
	logic [OCC_W-1:0]   occ_q, occ_d;
	logic [OCC_W-1:0]   cnt_q, cnt_d;
	logic [SEQ_W-1:0]   ack_seq_q, ack_seq_d;

	logic               ov_q;
	logic               okind_q;
	logic               olast_q;
	logic [STATUS_W-1:0] ostat_q;
	desc_t              odesc_q;
	logic [OUTST_W-1:0] oocc_q;

	logic               obuf_free;
	logic               load;
	logic               ld_kind;
	logic               ld_last;
	logic [STATUS_W-1:0] ld_stat;
	desc_t              ld_desc;
	logic [OCC_W-1:0]   ld_occ;

	assign obuf_free = !ov_q || m_tready;
	assign head_nxt  = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign tail_nxt  = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
	assign ptr_nxt   = (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;

	always_comb begin
		cmd_pop   = 1'b0;
		wr_en     = 1'b0;
		rd_addr   = ptr_q;
		state_d   = state_q;
		head_d    = head_q;
		tail_d    = tail_q;
		ptr_d     = ptr_q;
		occ_d     = occ_q;
		cnt_d     = cnt_q;
		ack_seq_d = ack_seq_q;
		load      = 1'b0;
		ld_kind   = KIND_STATUS;
		ld_last   = 1'b1;
		ld_stat   = STAT_ACCEPTED;
		ld_desc   = '0;
		ld_occ    = occ_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && obuf_free) begin
					cmd_pop = 1'b1;
					case (cmd.kind)
						CMD_ENQ: begin
							load = 1'b1;
							if (occ_q == FULL_OCC) begin
								ld_stat = STAT_DROPPED;
							end else begin
								wr_en  = 1'b1;
								tail_d = tail_nxt;
								occ_d  = occ_q + 1'b1;
								ld_occ = occ_q + 1'b1;
							end
						end
						CMD_ACK_IGN: begin
							load    = 1'b1;
							ld_stat = STAT_IGNORED;
						end
						CMD_ACK: begin
							if (occ_q == '0) begin
								load    = 1'b1;
								ld_stat = STAT_EMPTY;
							end else begin
								// head entry arrives from the ring next cycle
								rd_addr   = head_q;
								ack_seq_d = cmd.desc.seq;
								state_d   = ST_ACK;
							end
						end
						CMD_TMO: begin
							if (occ_q == '0) begin
								load    = 1'b1;
								ld_stat = STAT_EMPTY;
							end else begin
								rd_addr = head_q;
								ptr_d   = head_q;
								cnt_d   = '0;
								state_d = ST_REPLAY;
							end
						end
						default: begin
							load = 1'b0;
						end
					endcase
				end
			end
			ST_ACK: begin
				if (obuf_free) begin
					load    = 1'b1;
					state_d = ST_IDLE;
					if (rd_data_q.seq == ack_seq_q) begin
						ld_stat = STAT_RETIRED;
						head_d  = head_nxt;
						occ_d   = occ_q - 1'b1;
						ld_occ  = occ_q - 1'b1;
					end else begin
						ld_stat = STAT_IGNORED;
					end
				end
			end
			ST_REPLAY: begin
				if (obuf_free) begin
					load    = 1'b1;
					ld_kind = KIND_DESC;
					ld_desc = rd_data_q;
					ld_last = ((cnt_q + 1'b1) == occ_q);
					ptr_d   = ptr_nxt;
					rd_addr = ptr_nxt;
					cnt_d   = cnt_q + 1'b1;
					if (ld_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			ptr_q   <= '0;
			occ_q   <= '0;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			ptr_q   <= ptr_d;
			occ_q   <= occ_d;
			cnt_q   <= cnt_d;
			if (load) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ack_seq_q <= ack_seq_d;
		if (load) begin
			okind_q <= ld_kind;
			olast_q <= ld_last;
			ostat_q <= ld_stat;
			odesc_q <= ld_desc;
			oocc_q  <= OUTST_W'(ld_occ);
		end
	end

	// descriptor ring, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[tail_q] <= cmd.desc;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign m_tvalid  = ov_q;
	assign m_tuser   = okind_q;
	assign m_tlast   = olast_q;
	assign m_tdata   = {{OUT_PAD_W{1'b0}}, oocc_q, odesc_q.buf_addr, odesc_q.len,
		odesc_q.ptype, odesc_q.seq, odesc_q.chan, ostat_q};
	assign occupancy = occ_q;

endmodule

`default_nettype wire

@@ hw/rtl/go_back_n_send_window.sv @@
// go_back_n_send_window: top level of the go-back-n sender window
// depends on gbnsw_pkg, gbnsw_front, gbnsw_cmd_fifo, gbnsw_back and the macros header
//
// usage:
//  - s_* carries commands: s_tuser is the opcode (enqueue, ack, timeout), s_tdata
//    the packet descriptor; opcode 3 is taken and dropped without any result
//  - cfg_* writes the ack type code (reset value 1); write it only while idle
//  - m_* carries results: m_tuser is the result kind (status or retransmit
//    descriptor), m_tlast marks the final result of one command
//  - path: m_tvalid rises once the input transfer has passed the front register,
//    then the command queue, then the output register; an ack of the ack type on a
//    non-empty window or a timeout on a non-empty window also waits for the ring read
//  - back end: enqueue, an ack of another type and an ack or timeout on an
//    empty window are finished in the idle state; an ack of the ack type on a
//    non-empty window also passes the ack state, since the head sequence comes from
//    the ring's registered read port; a timeout replays every outstanding
//    descriptor, one ring read per descriptor, before the next command is popped
//  - reset: window empty, head and tail at zero; ring contents are not cleared
//    and need no clearing pass
//  - when m_tready is low the output register holds, the back end stops, the
//    two-entry command queue fills and s_tready drops
`default_nettype none

`include "go_back_n_send_window_macros.svh"

module go_back_n_send_window
	import gbnsw_pkg::*;
#(
	parameter int unsigned WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// input stream
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// [9:0] channel_id, [41:10] seq_number, [49:42] packet_type,
	// [65:50] payload_length, [97:66] buffer_address, rest zero
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// [1:0] opcode
	input  wire logic [OPCODE_W-1:0]    s_tuser,
	// ack type code write
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [PTYPE_W-1:0]     cfg_data,
	// result stream
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// [2:0] status_code, [12:3] out_channel, [44:13] out_seq, [52:45] out_type,
	// [68:53] out_length, [100:69] out_buffer, [105:101] outstanding, rest zero
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	// [0] result_kind
	output logic                        m_tuser,
	// last_of_run
	output logic                        m_tlast
);

	localparam int unsigned OCC_W = $clog2(WINDOW_DEPTH + 1);

	// front to queue
	logic             push_valid;
	logic             push_ready;
	cmd_t             push_cmd;
	// queue to back
	logic             cmd_valid;
	logic             cmd_pop;
	cmd_t             cmd;
	// window fill level, for checking
	logic [OCC_W-1:0] occ;

	gbnsw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	gbnsw_cmd_fifo #(
		.DEPTH (CMD_FIFO_DEPTH)
	) u_cmd_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (cmd_valid),
		.pop        (cmd_pop),
		.pop_cmd    (cmd)
	);

	gbnsw_back #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.occupancy (occ)
	);

	// window never holds more than its depth
	`GBNSW_ASSERT_IMPL(a_occ_bound, clk, arst_n, 1'b1, occ <= OCC_W'(WINDOW_DEPTH))
	// a replayed descriptor always carries the zero status code
	`GBNSW_ASSERT_IMPL(a_desc_status, clk, arst_n, m_tvalid && m_tuser == KIND_DESC,
		m_tdata[STATUS_W-1:0] == STAT_ACCEPTED)
	// a status result is always the only result of its command
	`GBNSW_ASSERT_IMPL(a_status_last, clk, arst_n, m_tvalid && m_tuser == KIND_STATUS,
		m_tlast)
	// window fill level moves by at most one per cycle
	`GBNSW_ASSERT_NEXT(a_occ_step, clk, arst_n, 1'b1,
		occ == $past(occ) || occ == $past(occ) + 1'b1 || occ == $past(occ) - 1'b1)

endmodule

`default_nettype wire
